>>> hdl/bpt_pkg.sv
// Shared types, constants and register codes of the barometric compensation block.
package bpt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SENS_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMPCO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TEMPCO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TREF_WORD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ORD  = 3'd6;

  // 20.00 C reference and the offset that moves the -15.00 C test onto the same quotient
  localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
  localparam logic signed [19:0] VLOW_SHIFT = 20'sd3500;

  typedef struct packed {
    logic [15:0] sens_base;
    logic [15:0] off_base;
    logic [15:0] sens_tempco;
    logic [15:0] off_tempco;
    logic [15:0] tref_word;
    logic [15:0] temp_slope;
    logic        second_order;
  } bpt_cfg_t;

  // first-order results and second-order operands
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [19:0] temp1;
    logic signed [18:0] lo;
    logic signed [19:0] vlo;
    logic [16:0]        t2;
    logic signed [35:0] off1;
    logic signed [35:0] sens1;
    logic               low;
    logic               vlow;
  } bpt_first_t;

  // compensated temperature, offset and sensitivity
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [20:0] temp;
    logic signed [41:0] off;
    logic signed [41:0] sens;
  } bpt_comp_t;

endpackage

>>> hdl/bpt_if.sv
// Valid/ready channel interfaces for raw sample pairs and compensated results.
interface bpt_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pressure_raw;
  logic [23:0] temp_raw;
  modport source (output valid, output pressure_raw, output temp_raw, input ready);
  modport sink (input valid, input pressure_raw, input temp_raw, output ready);
endinterface

interface bpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature;
  logic signed [31:0] pressure;
  modport source (output valid, output temperature, output pressure, input ready);
  modport sink (input valid, input temperature, input pressure, output ready);
endinterface

>>> hdl/bpt_cfg.sv
// Calibration word and mode register file.
module bpt_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output bpt_pkg::bpt_cfg_t                  cfg
);
  import bpt_pkg::*;

  bpt_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{second_order: 1'b1, default: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SENS_BASE:   cfg_r.sens_base    <= cfg_wdata;
        CFG_OFF_BASE:    cfg_r.off_base     <= cfg_wdata;
        CFG_SENS_TEMPCO: cfg_r.sens_tempco  <= cfg_wdata;
        CFG_OFF_TEMPCO:  cfg_r.off_tempco   <= cfg_wdata;
        CFG_TREF_WORD:   cfg_r.tref_word    <= cfg_wdata;
        CFG_TEMP_SLOPE:  cfg_r.temp_slope   <= cfg_wdata;
        CFG_SECOND_ORD:  cfg_r.second_order <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/bpt_first.sv
// First-order stages: temperature difference, coefficient products, truncated quotients.
module bpt_first (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpt_pkg::bpt_cfg_t     cfg,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [23:0]           up_d1,
  input  logic [23:0]           up_d2,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output bpt_pkg::bpt_first_t   dn_data
);
  import bpt_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic [23:0]        d1_1_r, d1_2_r;
  logic signed [24:0] dt_nxt, dt_r;
  logic signed [41:0] pt_nxt, po_nxt, ps_nxt;
  logic signed [41:0] pt_r, po_r, ps_r;
  logic signed [49:0] pdd_nxt, pdd_r;

  logic signed [41:0] pt_b;
  logic signed [42:0] off_s;
  logic signed [43:0] sens_s;
  logic signed [18:0] q_nxt;
  bpt_first_t         s3_nxt, s3_r;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // stage 1: temperature difference
  assign dt_nxt = $signed({1'b0, up_d2}) - $signed({1'b0, cfg.tref_word, 8'h00});

  // stage 2: coefficient products
  assign pt_nxt  = 42'(dt_r) * 42'($signed({1'b0, cfg.temp_slope}));
  assign po_nxt  = 42'(dt_r) * 42'($signed({1'b0, cfg.off_tempco}));
  assign ps_nxt  = 42'(dt_r) * 42'($signed({1'b0, cfg.sens_tempco}));
  assign pdd_nxt = 50'(dt_r) * 50'(dt_r);

  // stage 3: truncate toward zero by biasing negative products
  always_comb begin
    pt_b   = pt_r + (pt_r[41] ? 42'sd8388607 : 42'sd0);
    q_nxt  = pt_b[41:23];
    off_s  = $signed({4'd0, cfg.off_base, 23'd0}) + 43'(po_r)
           + (po_r[41] ? 43'sd127 : 43'sd0);
    sens_s = $signed({5'd0, cfg.sens_base, 23'd0}) + 44'(ps_r)
           + (ps_r[41] ? 44'sd255 : 44'sd0);

    s3_nxt.d1    = d1_2_r;
    s3_nxt.lo    = q_nxt;
    s3_nxt.temp1 = 20'(q_nxt) + TEMP_REF;
    s3_nxt.vlo   = 20'(q_nxt) + VLOW_SHIFT;
    s3_nxt.t2    = pdd_r[47:31];
    s3_nxt.off1  = off_s[42:7];
    s3_nxt.sens1 = sens_s[43:8];
    s3_nxt.low   = cfg.second_order & q_nxt[18];
    s3_nxt.vlow  = s3_nxt.low & s3_nxt.vlo[19];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      d1_1_r <= up_d1;
      dt_r   <= dt_nxt;
    end
    if (rdy2) begin
      d1_2_r <= d1_1_r;
      pt_r   <= pt_nxt;
      po_r   <= po_nxt;
      ps_r   <= ps_nxt;
      pdd_r  <= pdd_nxt;
    end
    if (rdy3) s3_r <= s3_nxt;
  end

  assign dn_valid = v3_r;
  assign dn_data  = s3_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && s3_r.low |-> s3_r.temp1 < TEMP_REF)
    else $error("low-temperature flag set at or above 20 C");

endmodule

>>> hdl/bpt_second.sv
// Second-order stages: squared deviations, OFF2/SENS2/T2 corrections, subtraction.
module bpt_second (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  bpt_pkg::bpt_first_t   up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output bpt_pkg::bpt_comp_t    dn_data
);
  import bpt_pkg::*;

  logic v4_r, v5_r, v6_r;
  logic rdy4, rdy5, rdy6;

  bpt_first_t  s4_r, s5_r;
  logic [37:0] lo2_nxt, vlo2_nxt, lo2_r, vlo2_r;
  logic [41:0] lo5, v7, v11;
  logic [41:0] off2_nxt, sens2_nxt, off2_r, sens2_r;
  bpt_comp_t   s6_nxt, s6_r;

  assign rdy6     = !v6_r || dn_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign up_ready = rdy4;

  // stage 4: squares
  assign lo2_nxt  = 38'(38'(up_data.lo) * 38'(up_data.lo));
  assign vlo2_nxt = 38'(38'(up_data.vlo) * 38'(up_data.vlo));

  // stage 5: correction terms
  always_comb begin
    lo5       = {4'd0, lo2_r} + {2'd0, lo2_r, 2'd0};
    v7        = {1'b0, vlo2_r, 3'd0} - {4'd0, vlo2_r};
    v11       = {1'b0, vlo2_r, 3'd0} + {3'd0, vlo2_r, 1'b0} + {4'd0, vlo2_r};
    off2_nxt  = (lo5 >> 1) + (s4_r.vlow ? v7 : 42'd0);
    sens2_nxt = (lo5 >> 2) + (s4_r.vlow ? (v11 >> 1) : 42'd0);
  end

  // stage 6: apply corrections
  always_comb begin
    s6_nxt.d1   = s5_r.d1;
    s6_nxt.temp = 21'(s5_r.temp1)
                - (s5_r.low ? $signed({4'd0, s5_r.t2}) : 21'sd0);
    s6_nxt.off  = 42'(s5_r.off1) - (s5_r.low ? $signed(off2_r) : 42'sd0);
    s6_nxt.sens = 42'(s5_r.sens1) - (s5_r.low ? $signed(sens2_r) : 42'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= up_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_r   <= up_data;
      lo2_r  <= lo2_nxt;
      vlo2_r <= vlo2_nxt;
    end
    if (rdy5) begin
      s5_r    <= s4_r;
      off2_r  <= off2_nxt;
      sens2_r <= sens2_nxt;
    end
    if (rdy6) s6_r <= s6_nxt;
  end

  assign dn_valid = v6_r;
  assign dn_data  = s6_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && s5_r.vlow |-> s5_r.low)
    else $error("below -15 C correction without the below 20 C correction");

endmodule

>>> hdl/bpt_press.sv
// Pressure stages: split D1*SENS product, truncated scaling, offset removal, output register.
module bpt_press (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bpt_pkg::bpt_comp_t   up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [31:0]   dn_temperature,
  output logic signed [31:0]   dn_pressure
);
  import bpt_pkg::*;

  logic v7_r, v8_r, v9_r, v10_r, v11_r;
  logic rdy7, rdy8, rdy9, rdy10, rdy11;

  logic signed [20:0] temp7_r, temp8_r, temp9_r, temp10_r;
  logic signed [41:0] off7_r, off8_r, off9_r;
  logic               neg7_r, neg8_r;
  logic [44:0]        pl_nxt, pl_r;
  logic signed [45:0] ph_nxt, ph_r;
  logic signed [63:0] prod_nxt, prod_r, pb;
  logic signed [42:0] q1_nxt, q1_r;
  logic signed [43:0] a_nxt, a_r, ab;
  logic signed [31:0] temp_out_r, pres_nxt, pres_out_r;

  assign rdy11    = !v11_r || dn_ready;
  assign rdy10    = !v10_r || rdy11;
  assign rdy9     = !v9_r || rdy10;
  assign rdy8     = !v8_r || rdy9;
  assign rdy7     = !v7_r || rdy8;
  assign up_ready = rdy7;

  // stage 7: low and high halves of D1*SENS
  assign pl_nxt = 45'(up_data.d1) * 45'(up_data.sens[20:0]);
  assign ph_nxt = 46'($signed({1'b0, up_data.d1})) * 46'($signed(up_data.sens[41:21]));

  // stage 8: recombine
  assign prod_nxt = $signed({ph_r[42:0], 21'd0}) + $signed({19'd0, pl_r});

  // stage 9: divide by 2^21 toward zero
  always_comb begin
    pb     = prod_r + (prod_r[63] ? 64'sd2097151 : 64'sd0);
    q1_nxt = pb[63:21];
  end

  // stage 10: remove offset
  assign a_nxt = 44'(q1_r) - 44'(off9_r);

  // stage 11: divide by 2^15 toward zero
  always_comb begin
    ab       = a_r + (a_r[43] ? 44'sd32767 : 44'sd0);
    pres_nxt = 32'($signed(ab[43:15]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else begin
      if (rdy7)  v7_r  <= up_valid;
      if (rdy8)  v8_r  <= v7_r;
      if (rdy9)  v9_r  <= v8_r;
      if (rdy10) v10_r <= v9_r;
      if (rdy11) v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      pl_r    <= pl_nxt;
      ph_r    <= ph_nxt;
      neg7_r  <= up_data.sens[41];
      temp7_r <= up_data.temp;
      off7_r  <= up_data.off;
    end
    if (rdy8) begin
      prod_r  <= prod_nxt;
      neg8_r  <= neg7_r;
      temp8_r <= temp7_r;
      off8_r  <= off7_r;
    end
    if (rdy9) begin
      q1_r    <= q1_nxt;
      temp9_r <= temp8_r;
      off9_r  <= off8_r;
    end
    if (rdy10) begin
      a_r      <= a_nxt;
      temp10_r <= temp9_r;
    end
    if (rdy11) begin
      pres_out_r <= pres_nxt;
      temp_out_r <= 32'(temp10_r);
    end
  end

  assign dn_valid       = v11_r;
  assign dn_temperature = temp_out_r;
  assign dn_pressure    = pres_out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    v8_r && !neg8_r |-> !prod_r[63])
    else $error("non-negative sensitivity gave a negative D1*SENS product");

endmodule

>>> hdl/baro_pressure_temp_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// Takes one raw pressure/temperature pair per cycle while in_bus.ready is high and returns
// temperature in 0.01 C and pressure in 0.01 mbar after the input beat, in input order. The eleven
// register stages are: temperature difference, coefficient products, first-order quotients,
// squares, second-order terms, corrections, split D1*SENS product, recombine, divide by 2^21,
// offset removal, divide by 2^15 into the output register. Each stage holds its own valid
// bit and advances whenever the stage after it is empty or moving, so bubbles close up and
// in_bus.ready stays high while any stage is free even with a result waiting at out_bus.
// Calibration words and the mode bit are written through the cfg_ port and must only change
// while no beat is in flight; second-order mode is selected after reset.
module baro_pressure_temp_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  bpt_in_if.sink                         in_bus,
  bpt_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bpt_pkg::*;

  bpt_cfg_t   cfg;
  logic       f_valid, f_ready;
  bpt_first_t f_data;
  logic       s_valid, s_ready;
  bpt_comp_t  s_data;

  bpt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpt_first u_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_bus.valid),
    .up_ready (in_bus.ready),
    .up_d1    (in_bus.pressure_raw),
    .up_d2    (in_bus.temp_raw),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_data  (f_data)
  );

  bpt_second u_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (s_valid),
    .dn_ready (s_ready),
    .dn_data  (s_data)
  );

  bpt_press u_press (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (s_valid),
    .up_ready       (s_ready),
    .up_data        (s_data),
    .dn_valid       (out_bus.valid),
    .dn_ready       (out_bus.ready),
    .dn_temperature (out_bus.temperature),
    .dn_pressure    (out_bus.pressure)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_bus.valid |-> in_bus.ready)
    else $error("input stalled with an empty output stage");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the barometric pressure and temperature compensation pipeline.
`timescale 1ns / 100ps

module testbench;
  import bpt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int PIPE_LATENCY = 11;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 110;

  class comp_scoreboard;
    typedef struct {
      logic signed [31:0] temperature;
      logic signed [31:0] pressure;
    } reading_t;

    localparam longint P2_7 = longint'(1) << 7;
    localparam longint P2_8 = longint'(1) << 8;
    localparam longint P2_15 = longint'(1) << 15;
    localparam longint P2_16 = longint'(1) << 16;
    localparam longint P2_21 = longint'(1) << 21;
    localparam longint P2_23 = longint'(1) << 23;
    localparam longint P2_31 = longint'(1) << 31;

    bpt_cfg_t regs;
    reading_t expected_q[$];
    int errors;
    int samples;
    int checked;
    int low_count;
    int vlow_count;

    function new();
      regs = '0;
      regs.second_order = 1'b1;
      errors = 0;
      samples = 0;
      checked = 0;
      low_count = 0;
      vlow_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SENS_BASE:   regs.sens_base = val;
        CFG_OFF_BASE:    regs.off_base = val;
        CFG_SENS_TEMPCO: regs.sens_tempco = val;
        CFG_OFF_TEMPCO:  regs.off_tempco = val;
        CFG_TREF_WORD:   regs.tref_word = val;
        CFG_TEMP_SLOPE:  regs.temp_slope = val;
        CFG_SECOND_ORD:  regs.second_order = val[0];
        default: ;
      endcase
    endfunction

    function reading_t compensate(logic [23:0] p_raw, logic [23:0] t_raw);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, lo, off2, sens2, vlo, p;
      reading_t r;
      d1 = p_raw;
      d2 = t_raw;
      c1 = regs.sens_base;
      c2 = regs.off_base;
      c3 = regs.sens_tempco;
      c4 = regs.off_tempco;
      c5 = regs.tref_word;
      c6 = regs.temp_slope;
      dt = d2 - c5 * 256;
      temp = 2000 + (dt * c6) / P2_23;
      off = c2 * P2_16 + (c4 * dt) / P2_7;
      sens = c1 * P2_15 + (c3 * dt) / P2_8;
      if (regs.second_order && temp < 2000) begin
        low_count++;
        t2 = (dt * dt) / P2_31;
        lo = temp - 2000;
        off2 = 5 * (lo * lo) / 2;
        sens2 = 5 * (lo * lo) / 4;
        if (temp < -1500) begin
          vlow_count++;
          vlo = temp + 1500;
          off2 += 7 * (vlo * vlo);
          sens2 += 11 * (vlo * vlo) / 2;
        end
        temp -= t2;
        off -= off2;
        sens -= sens2;
      end
      p = (d1 * sens / P2_21 - off) / P2_15;
      r.temperature = temp[31:0];
      r.pressure = p[31:0];
      return r;
    endfunction

    function void note_sample(logic [23:0] p_raw, logic [23:0] t_raw);
      expected_q.push_back(compensate(p_raw, t_raw));
      samples++;
    endfunction

    function void check_result(logic signed [31:0] temperature, logic signed [31:0] pressure);
      reading_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: temperature %0d pressure %0d",
                 $time, temperature, pressure);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (temperature !== exp_r.temperature) begin
        $display("%0t: temperature mismatch: expected %0d actual %0d",
                 $time, exp_r.temperature, temperature);
        errors++;
      end
      if (pressure !== exp_r.pressure) begin
        $display("%0t: pressure mismatch: expected %0d actual %0d",
                 $time, exp_r.pressure, pressure);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit burst;
  int idle_cycles;

  bpt_in_if in_ch();
  bpt_out_if out_ch();

  comp_scoreboard sb = new();

  baro_pressure_temp_compensation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic bpt_cfg_t typical_cfg(logic so);
    bpt_cfg_t c;
    c.sens_base = 16'd40127;
    c.off_base = 16'd36924;
    c.sens_tempco = 16'd23317;
    c.off_tempco = 16'd23282;
    c.tref_word = 16'd33464;
    c.temp_slope = 16'd28312;
    c.second_order = so;
    return c;
  endfunction

  function automatic logic [23:0] pick_press_raw();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // bias toward the reference point so both sides of the thresholds are hit
  function automatic logic [23:0] pick_temp_raw(logic [15:0] ref_word);
    int v;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      1, 2: v = int'(ref_word) * 256 + int'($urandom_range(0, 2097152)) - 1048576;
      3: v = int'(ref_word) * 256 + int'($urandom_range(0, 8192)) - 4096;
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[23:0];
  endfunction

  task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(bpt_cfg_t c);
    cfg_beat(CFG_SENS_BASE, c.sens_base);
    cfg_beat(CFG_OFF_BASE, c.off_base);
    cfg_beat(CFG_SENS_TEMPCO, c.sens_tempco);
    cfg_beat(CFG_OFF_TEMPCO, c.off_tempco);
    cfg_beat(CFG_TREF_WORD, c.tref_word);
    cfg_beat(CFG_TEMP_SLOPE, c.temp_slope);
    cfg_beat(CFG_SECOND_ORD, {15'($urandom_range(0, 32767)), c.second_order});
    cfg_beat(CFG_UNUSED_IDX, 16'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(logic [23:0] p_raw, logic [23:0] t_raw);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pressure_raw <= p_raw;
    in_ch.temp_raw <= t_raw;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(p_raw, t_raw);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  // result side: hold ready for a while, then drop it for a random gap
  initial begin
    int g;
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.temperature, out_ch.pressure);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    bpt_cfg_t c;
    logic [23:0] ref_d2;
    burst = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.pressure_raw <= '0;
    in_ch.temp_raw <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calibration words still at reset
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h000000, 24'hFFFFFF);
    drain();

    load_config(typical_cfg(1'b1));
    send_sample(24'd9085466, 24'd8569150);
    send_sample(24'd9085466, 24'd8000000);
    send_sample(24'd9085466, 24'd0);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'd7000000);
    drain();

    // slope of 2^13 and reference at 2^23: temperature steps once per 1024 counts
    c = typical_cfg(1'b1);
    c.tref_word = 16'd32768;
    c.temp_slope = 16'd8192;
    load_config(c);
    ref_d2 = 24'd8388608;
    send_sample(24'd9085466, ref_d2 - 24'd1023);
    send_sample(24'd9085466, ref_d2 - 24'd1024);
    send_sample(24'd9085466, ref_d2 - 24'd3584999);
    send_sample(24'd9085466, ref_d2 - 24'd3585024);
    drain();

    c.second_order = 1'b0;
    load_config(c);
    send_sample(24'd9085466, ref_d2 - 24'd1024);
    send_sample(24'd9085466, 24'd0);
    drain();

    c = '1;
    load_config(c);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'h800000, 24'h7FFFFF);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: c = typical_cfg(1'b1);
        1: c = typical_cfg(1'b0);
        2: c = '1;
        3: c = '0;
        default: begin
          c.sens_base = rand_word();
          c.off_base = rand_word();
          c.sens_tempco = rand_word();
          c.off_tempco = rand_word();
          c.tref_word = rand_word();
          c.temp_slope = rand_word();
          c.second_order = ($urandom_range(0, 3) != 0);
        end
      endcase
      load_config(c);
      burst = (ph % 3 == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_sample(pick_press_raw(), pick_temp_raw(c.tref_word));
      drain();
      burst = 1'b0;
    end

    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors += sb.pending();
    end
    $display("Sent %0d sample pairs over %0d calibration sets, checked %0d results.",
             sb.samples, RAND_PHASES + 5, sb.checked);
    $display("Second-order path taken %0d times, below -15 C %0d times.",
             sb.low_count, sb.vlow_count);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
